@@ rtl/hrcd_pkg.sv @@
// Package for the HTTP request completion detector.
// Holds word types, status and method codes, character constants and pattern tables.
// No dependencies.
package hrcd_pkg;

  // Width of the accepted body length; values above 2^LENGTH_BITS - 1 are flagged
  localparam int LENGTH_BITS = 32;
  localparam int ACC_BITS    = LENGTH_BITS + 4;

  // Result status codes
  localparam logic [1:0] ST_WAITING  = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_UNKNOWN  = 2'd2;
  localparam logic [1:0] ST_BAD_LEN  = 2'd3;

  // Method kinds (MK_UNKNOWN is internal only; reported as "not known")
  localparam logic [1:0] MK_PENDING  = 2'd0;
  localparam logic [1:0] MK_GET      = 2'd1;
  localparam logic [1:0] MK_POST     = 2'd2;
  localparam logic [1:0] MK_UNKNOWN  = 2'd3;

  // Length value phases per header spelling
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_READING  = 2'd1;
  localparam logic [1:0] PH_GOOD     = 2'd2;
  localparam logic [1:0] PH_BAD      = 2'd3;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;

  // Last index of the length header pattern
  localparam logic [3:0] LEN_PAT_LAST = 4'd15;
  // Prefix lengths
  localparam logic [2:0] GET_LEN  = 3'd4;
  localparam logic [2:0] POST_LEN = 3'd5;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_request;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  method;
    logic [31:0] content_length;
  } out_word_t;

  // Controls from the core to each length scanner
  typedef struct packed {
    logic       fire;
    logic       clear;
    logic       scan_en;
    logic       prev_cr;
    logic [7:0] data_byte;
  } scan_ctl_t;

  // Next-state view of one length scanner
  typedef struct packed {
    logic [1:0]             phase;
    logic [LENGTH_BITS-1:0] value;
  } scan_res_t;

  // "Content-Length: " / "Content-length: " by index
  function automatic logic [7:0] len_pat_byte(input logic [3:0] idx, input logic lower);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "C";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = lower ? 8'h6C : 8'h4C;
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      4'd14:   ch = ":";
      default: ch = CH_SPACE;
    endcase
    return ch;
  endfunction

  // "GET "
  function automatic logic [7:0] get_byte(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = CH_G;
      2'd1:    ch = "E";
      2'd2:    ch = "T";
      default: ch = CH_SPACE;
    endcase
    return ch;
  endfunction

  // "POST "
  function automatic logic [7:0] post_byte(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_P;
      3'd1:    ch = "O";
      3'd2:    ch = "S";
      3'd3:    ch = "T";
      default: ch = CH_SPACE;
    endcase
    return ch;
  endfunction

  // Low 32 bits of a length value, zero-extended when narrower
  function automatic logic [31:0] len_to_out(input logic [LENGTH_BITS-1:0] v);
    logic [95:0] w;
    w = 96'(v);
    return w[31:0];
  endfunction

endpackage

@@ rtl/http_request_completion_detector_unit.sv @@
// HTTP request completion detector, top level.
// Holds the input word register and the result register around hrcd_core.
// Depends on hrcd_pkg and hrcd_core.
//
// Usage:
//   Request bytes enter on the in_ channel, one word per byte; start_of_request
//   marks the first byte of a new request and clears all per-request state.
//   Every accepted byte yields exactly one result word on the out_ channel:
//   status (waiting, complete, unknown method, missing or bad length), the
//   method seen so far, and the parsed body length once a POST header ends.
//   Once a verdict is given it is repeated for each further byte until the
//   next start_of_request.
// Timing:
//   A byte accepted into the input register is processed when it fires into
//   hrcd_core; its result is registered in the result register, which raises
//   out_valid. One byte per cycle is sustained while out_stall is low; the
//   per-byte work is one pass through the prefix matchers, the two header
//   scanners and their x10 accumulators.
// Reset and stall:
//   rst_n (synchronous, active low) empties both registers and clears the
//   request state. When out_stall holds the result register full, the input
//   register keeps its byte and in_stall rises once it is occupied as well.
module http_request_completion_detector_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrcd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output hrcd_pkg::out_word_t out_word
);

  logic                in_full_r, in_full_nxt;
  hrcd_pkg::in_word_t  in_word_r;
  logic                out_valid_r, out_valid_nxt;
  hrcd_pkg::out_word_t out_word_r;
  hrcd_pkg::out_word_t core_result;
  logic                advance, fire, accept;

  // Handshake: process when the result register is free or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_full_r && advance;
  assign in_stall = in_full_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_full_nxt   = accept ? 1'b1 : (fire ? 1'b0 : in_full_r);
    out_valid_nxt = fire ? 1'b1 : (out_valid_r && out_stall);
  end

  hrcd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .word   (in_word_r),
    .result (core_result)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_word_r <= in_word;
    end
    if (fire) begin
      out_word_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ rtl/hrcd_len_scan.sv @@
// Length header scanner for one spelling of the Content-Length header.
// Matches the header name, then accumulates the decimal value (x10 + digit).
// Depends on hrcd_pkg.
module hrcd_len_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  hrcd_pkg::scan_ctl_t ctl,
  input  logic               lower_sel,
  output hrcd_pkg::scan_res_t res
);

  logic [3:0]                       prog_r, prog_c, prog_nxt;
  logic [1:0]                       phase_r, phase_c, phase_nxt;
  logic [hrcd_pkg::LENGTH_BITS-1:0] value_r, value_c, value_nxt;
  logic                             digit_r, digit_c, digit_nxt;
  logic [hrcd_pkg::ACC_BITS-1:0]    prod;
  logic [3:0]                       dval;
  logic                             digit_hit;

  // Start of request clears the scanner before the byte is applied
  always_comb begin
    prog_c  = ctl.clear ? 4'd0 : prog_r;
    phase_c = ctl.clear ? hrcd_pkg::PH_IDLE : phase_r;
    value_c = ctl.clear ? '0 : value_r;
    digit_c = ctl.clear ? 1'b0 : digit_r;
  end

  // Multiply-by-ten accumulate; overflow shows in the top four bits
  always_comb begin
    digit_hit = (ctl.data_byte >= hrcd_pkg::CH_ZERO) && (ctl.data_byte <= hrcd_pkg::CH_NINE);
    dval      = 4'(ctl.data_byte - hrcd_pkg::CH_ZERO);
    prod      = (hrcd_pkg::ACC_BITS'(value_c) << 3) + (hrcd_pkg::ACC_BITS'(value_c) << 1)
              + hrcd_pkg::ACC_BITS'(dval);
  end

  // Name match and value phases
  always_comb begin
    prog_nxt  = prog_c;
    phase_nxt = phase_c;
    value_nxt = value_c;
    digit_nxt = digit_c;
    if (ctl.scan_en) begin
      case (phase_c)
        hrcd_pkg::PH_IDLE: begin
          if (ctl.data_byte == hrcd_pkg::len_pat_byte(prog_c, lower_sel)) begin
            if (prog_c == hrcd_pkg::LEN_PAT_LAST) begin
              phase_nxt = hrcd_pkg::PH_READING;
              value_nxt = '0;
              digit_nxt = 1'b0;
              prog_nxt  = 4'd0;
            end else begin
              prog_nxt = prog_c + 4'd1;
            end
          end else begin
            prog_nxt = (ctl.data_byte == hrcd_pkg::CH_C) ? 4'd1 : 4'd0;
          end
        end
        hrcd_pkg::PH_READING: begin
          if (ctl.prev_cr) begin
            phase_nxt = (ctl.data_byte == hrcd_pkg::CH_LF && digit_c) ?
                        hrcd_pkg::PH_GOOD : hrcd_pkg::PH_BAD;
          end else if (digit_hit) begin
            if (prod[hrcd_pkg::ACC_BITS-1:hrcd_pkg::LENGTH_BITS] != 4'd0) begin
              phase_nxt = hrcd_pkg::PH_BAD;
            end else begin
              value_nxt = prod[hrcd_pkg::LENGTH_BITS-1:0];
              digit_nxt = 1'b1;
            end
          end else if (ctl.data_byte != hrcd_pkg::CH_CR) begin
            phase_nxt = hrcd_pkg::PH_BAD;
          end
        end
        default: ;
      endcase
    end
  end

  assign res.phase = phase_nxt;
  assign res.value = value_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r  <= 4'd0;
      phase_r <= hrcd_pkg::PH_IDLE;
      value_r <= '0;
      digit_r <= 1'b0;
    end else if (ctl.fire) begin
      prog_r  <= prog_nxt;
      phase_r <= phase_nxt;
      value_r <= value_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

@@ rtl/hrcd_core.sv @@
// Per-byte request state: method prefix, header terminator, body count, verdict.
// Instantiates two hrcd_len_scan units (both header spellings); depends on hrcd_pkg.
module hrcd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  hrcd_pkg::in_word_t  word,
  output hrcd_pkg::out_word_t result
);

  logic [1:0]                       mk_r, mk_c, mk_nxt;
  logic [2:0]                       pp_r, pp_c, pp_nxt;
  logic [1:0]                       cand_r, cand_c, cand_nxt, cand_v;
  logic [1:0]                       term_r, term_c, term_nxt;
  logic                             hd_r, hd_c, hd_nxt;
  logic                             fin_r, fin_c, fin_nxt;
  logic [1:0]                       verdict_r, verdict_c, verdict_nxt;
  logic                             lok_r, lok_c, lok_nxt;
  logic [hrcd_pkg::LENGTH_BITS-1:0] chosen_r, chosen_c, chosen_nxt;
  logic [hrcd_pkg::LENGTH_BITS-1:0] body_r, body_c, body_nxt;
  logic                             clear, bad;
  logic [7:0]                       b;
  logic [1:0]                       eoh_phase;
  logic [hrcd_pkg::LENGTH_BITS-1:0] eoh_value;
  hrcd_pkg::scan_ctl_t              ctl;
  hrcd_pkg::scan_res_t              upper_res, lower_res;
  logic                             scan_en;

  assign clear = word.start_of_request;
  assign b     = word.data_byte;

  // State as seen by this byte (cleared on start of request)
  always_comb begin
    mk_c      = clear ? hrcd_pkg::MK_PENDING : mk_r;
    pp_c      = clear ? 3'd0 : pp_r;
    cand_c    = clear ? hrcd_pkg::MK_PENDING : cand_r;
    term_c    = clear ? 2'd0 : term_r;
    hd_c      = clear ? 1'b0 : hd_r;
    fin_c     = clear ? 1'b0 : fin_r;
    verdict_c = clear ? hrcd_pkg::ST_WAITING : verdict_r;
    lok_c     = clear ? 1'b0 : lok_r;
    chosen_c  = clear ? '0 : chosen_r;
    body_c    = clear ? '0 : body_r;
  end

  // Scanners see header bytes; if this byte breaks the method their state is moot
  assign scan_en = !fin_c && !hd_c;

  // Scanner controls
  always_comb begin
    ctl.fire      = fire;
    ctl.clear     = clear;
    ctl.scan_en   = scan_en;
    ctl.prev_cr   = term_c[0];
    ctl.data_byte = b;
  end

  hrcd_len_scan u_upper (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .lower_sel (1'b0),
    .res       (upper_res)
  );

  hrcd_len_scan u_lower (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .lower_sel (1'b1),
    .res       (lower_res)
  );

  // Lower-case spelling wins when it was seen
  always_comb begin
    if (lower_res.phase == hrcd_pkg::PH_IDLE) begin
      eoh_phase = upper_res.phase;
      eoh_value = upper_res.value;
    end else begin
      eoh_phase = lower_res.phase;
      eoh_value = lower_res.value;
    end
  end

  // Method, terminator, end of header and body count
  always_comb begin
    mk_nxt      = mk_c;
    pp_nxt      = pp_c;
    cand_nxt    = cand_c;
    term_nxt    = term_c;
    hd_nxt      = hd_c;
    fin_nxt     = fin_c;
    verdict_nxt = verdict_c;
    lok_nxt     = lok_c;
    chosen_nxt  = chosen_c;
    body_nxt    = body_c;
    bad         = 1'b0;
    cand_v      = cand_c;
    if (!fin_c) begin
      // method prefix
      if (mk_c == hrcd_pkg::MK_PENDING) begin
        if (pp_c == 3'd0) begin
          if (b == hrcd_pkg::CH_G) begin
            cand_v = hrcd_pkg::MK_GET;
          end else if (b == hrcd_pkg::CH_P) begin
            cand_v = hrcd_pkg::MK_POST;
          end else begin
            bad = 1'b1;
          end
        end
        if (!bad) begin
          if (cand_v == hrcd_pkg::MK_GET) begin
            if (b != hrcd_pkg::get_byte(pp_c[1:0])) begin
              bad = 1'b1;
            end else begin
              pp_nxt = pp_c + 3'd1;
              if (pp_nxt >= hrcd_pkg::GET_LEN) mk_nxt = hrcd_pkg::MK_GET;
            end
          end else begin
            if (pp_c > 3'd4 || b != hrcd_pkg::post_byte(pp_c)) begin
              bad = 1'b1;
            end else begin
              pp_nxt = pp_c + 3'd1;
              if (pp_nxt >= hrcd_pkg::POST_LEN) mk_nxt = hrcd_pkg::MK_POST;
            end
          end
        end
        cand_nxt = cand_v;
        if (bad) begin
          mk_nxt      = hrcd_pkg::MK_UNKNOWN;
          fin_nxt     = 1'b1;
          verdict_nxt = hrcd_pkg::ST_UNKNOWN;
        end
      end
      if (!fin_nxt) begin
        if (!hd_c) begin
          // header: track CR LF CR LF
          if (b == hrcd_pkg::CH_CR) begin
            term_nxt = (term_c == 2'd2) ? 2'd3 : 2'd1;
          end else if (b == hrcd_pkg::CH_LF && term_c[0]) begin
            if (term_c == 2'd3) begin
              term_nxt = 2'd0;
              hd_nxt   = 1'b1;
              if (mk_nxt == hrcd_pkg::MK_GET) begin
                fin_nxt     = 1'b1;
                verdict_nxt = hrcd_pkg::ST_COMPLETE;
              end else if (mk_nxt == hrcd_pkg::MK_POST) begin
                if (eoh_phase != hrcd_pkg::PH_GOOD) begin
                  fin_nxt     = 1'b1;
                  verdict_nxt = hrcd_pkg::ST_BAD_LEN;
                end else begin
                  lok_nxt    = 1'b1;
                  chosen_nxt = eoh_value;
                  if (eoh_value == '0) begin
                    fin_nxt     = 1'b1;
                    verdict_nxt = hrcd_pkg::ST_COMPLETE;
                  end
                end
              end
            end else begin
              term_nxt = 2'd2;
            end
          end else begin
            term_nxt = 2'd0;
          end
        end else if (mk_nxt == hrcd_pkg::MK_POST && lok_c) begin
          // body bytes
          body_nxt = body_c + hrcd_pkg::LENGTH_BITS'(1);
          if (body_nxt >= chosen_c) begin
            fin_nxt     = 1'b1;
            verdict_nxt = hrcd_pkg::ST_COMPLETE;
          end
        end
      end
    end
  end

  // Result word from the updated state
  always_comb begin
    result.status = verdict_nxt;
    result.method = (mk_nxt == hrcd_pkg::MK_GET || mk_nxt == hrcd_pkg::MK_POST) ?
                    mk_nxt : hrcd_pkg::MK_PENDING;
    result.content_length = (mk_nxt == hrcd_pkg::MK_POST && lok_nxt) ?
                            hrcd_pkg::len_to_out(chosen_nxt) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mk_r      <= hrcd_pkg::MK_PENDING;
      pp_r      <= 3'd0;
      cand_r    <= hrcd_pkg::MK_PENDING;
      term_r    <= 2'd0;
      hd_r      <= 1'b0;
      fin_r     <= 1'b0;
      verdict_r <= hrcd_pkg::ST_WAITING;
      lok_r     <= 1'b0;
      chosen_r  <= '0;
      body_r    <= '0;
    end else if (fire) begin
      mk_r      <= mk_nxt;
      pp_r      <= pp_nxt;
      cand_r    <= cand_nxt;
      term_r    <= term_nxt;
      hd_r      <= hd_nxt;
      fin_r     <= fin_nxt;
      verdict_r <= verdict_nxt;
      lok_r     <= lok_nxt;
      chosen_r  <= chosen_nxt;
      body_r    <= body_nxt;
    end
  end

endmodule

@@ sim/tb_http_request_completion_detector_unit.sv @@
`timescale 1ns / 1ps
// Testbench for http_request_completion_detector_unit: directed requests, then random requests.
// Every result word is checked against a byte-by-byte predictor, or against the hand-given word of a typed row.
// Depends on hrcd_pkg and the detector RTL.
module tb_http_request_completion_detector_unit;

  localparam int TARGET_BYTES = 1500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  // One length header scanner of the predictor
  typedef struct {
    logic [3:0]  prog;
    logic [63:0] val;
    logic [1:0]  phase;
    bit          dig;
  } len_scan_t;

  // One row of the directed part
  typedef struct {
    bit                  sor;
    int                  raw;        // >= 0: send this single byte instead of text
    string               text;
    bit                  typed;      // last byte's result given by hand
    hrcd_pkg::out_word_t exp_word;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  hrcd_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall;
  hrcd_pkg::out_word_t out_word;

  http_request_completion_detector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state of the predictor
  logic [1:0]  method_seen;
  logic [1:0]  verdict;
  logic [1:0]  candidate;
  logic [2:0]  prefix_pos;
  logic [1:0]  crlf_prog;
  bit          header_ended;
  bit          verdict_given;
  bit          length_good;
  logic [63:0] body_len;
  logic [63:0] body_seen;
  len_scan_t   upper_scan;
  len_scan_t   lower_scan;

  hrcd_pkg::out_word_t expected_words[$];
  dir_row_t            directed_rows[$];
  int                  mismatch_cnt = 0;
  int                  live_bytes = 0;
  int                  cycle_cnt = 0;
  bit                  tx_burst = 0;
  bit                  rx_burst = 0;

  function void clear_request();
    method_seen   = hrcd_pkg::MK_PENDING;
    verdict       = hrcd_pkg::ST_WAITING;
    candidate     = hrcd_pkg::MK_PENDING;
    prefix_pos    = '0;
    crlf_prog     = '0;
    header_ended  = 0;
    verdict_given = 0;
    length_good   = 0;
    body_len      = '0;
    body_seen     = '0;
    upper_scan    = '{4'd0, 64'd0, hrcd_pkg::PH_IDLE, 1'b0};
    lower_scan    = '{4'd0, 64'd0, hrcd_pkg::PH_IDLE, 1'b0};
  endfunction

  function void settle(logic [1:0] code);
    verdict       = code;
    verdict_given = 1;
  endfunction

  // Advance one spelling of the length header by one byte
  function automatic len_scan_t scan_len(len_scan_t s, string pat, logic [7:0] b, bit prev_cr);
    int          p;
    logic [63:0] d;
    logic [63:0] lim;
    lim = {64{1'b1}} >> (64 - hrcd_pkg::LENGTH_BITS);
    if (s.phase == hrcd_pkg::PH_IDLE) begin
      p = s.prog;
      if (b == 8'(pat[p])) begin
        p++;
        if (p == 16) begin
          s.phase = hrcd_pkg::PH_READING;
          s.val   = '0;
          s.dig   = 0;
          p       = 0;
        end
        s.prog = p[3:0];
      end else begin
        s.prog = (b == hrcd_pkg::CH_C) ? 4'd1 : 4'd0;
      end
    end else if (s.phase == hrcd_pkg::PH_READING) begin
      if (prev_cr) begin
        s.phase = (b == hrcd_pkg::CH_LF && s.dig) ? hrcd_pkg::PH_GOOD : hrcd_pkg::PH_BAD;
      end else if (b >= hrcd_pkg::CH_ZERO && b <= hrcd_pkg::CH_NINE) begin
        d = 64'(b - hrcd_pkg::CH_ZERO);
        if (s.val > (lim - d) / 10) begin
          s.phase = hrcd_pkg::PH_BAD;
        end else begin
          s.val = s.val * 10 + d;
          s.dig = 1;
        end
      end else if (b != hrcd_pkg::CH_CR) begin
        s.phase = hrcd_pkg::PH_BAD;
      end
    end
    return s;
  endfunction

  // Method prefix: "GET " or "POST ", anything else is unknown
  function void take_method(logic [7:0] b);
    string get_txt;
    string post_txt;
    get_txt  = "GET ";
    post_txt = "POST ";
    if (method_seen == hrcd_pkg::MK_PENDING) begin
      if (prefix_pos == 0) begin
        if (b == hrcd_pkg::CH_G) candidate = hrcd_pkg::MK_GET;
        else if (b == hrcd_pkg::CH_P) candidate = hrcd_pkg::MK_POST;
        else candidate = hrcd_pkg::MK_UNKNOWN;
      end
      if (candidate == hrcd_pkg::MK_GET && b == 8'(get_txt[prefix_pos[1:0]])) begin
        prefix_pos++;
        if (prefix_pos >= 4) method_seen = hrcd_pkg::MK_GET;
      end else if (candidate == hrcd_pkg::MK_POST && prefix_pos <= 4 &&
                   b == 8'(post_txt[prefix_pos])) begin
        prefix_pos++;
        if (prefix_pos >= 5) method_seen = hrcd_pkg::MK_POST;
      end else begin
        method_seen = hrcd_pkg::MK_UNKNOWN;
        settle(hrcd_pkg::ST_UNKNOWN);
      end
    end
  endfunction

  // Expected result word for one accepted input word
  function hrcd_pkg::out_word_t track_byte(hrcd_pkg::in_word_t w);
    logic [7:0]          b;
    bit                  prev_cr;
    logic [1:0]          ph;
    logic [63:0]         v;
    hrcd_pkg::out_word_t r;
    b = w.data_byte;
    live_bytes++;
    if (w.start_of_request) clear_request();
    if (!verdict_given) begin
      take_method(b);
    end
    if (!verdict_given) begin
      if (!header_ended) begin
        prev_cr    = crlf_prog[0];
        upper_scan = scan_len(upper_scan, "Content-Length: ", b, prev_cr);
        lower_scan = scan_len(lower_scan, "Content-length: ", b, prev_cr);
        if (b == hrcd_pkg::CH_CR) begin
          crlf_prog = (crlf_prog == 2'd2) ? 2'd3 : 2'd1;
        end else if (b == hrcd_pkg::CH_LF && crlf_prog[0]) begin
          if (crlf_prog == 2'd3) begin
            crlf_prog    = 2'd0;
            header_ended = 1;
            // lower-case spelling wins when it was seen at all
            ph = lower_scan.phase;
            v  = lower_scan.val;
            if (ph == hrcd_pkg::PH_IDLE) begin
              ph = upper_scan.phase;
              v  = upper_scan.val;
            end
            if (method_seen == hrcd_pkg::MK_GET) begin
              settle(hrcd_pkg::ST_COMPLETE);
            end else if (method_seen == hrcd_pkg::MK_POST) begin
              if (ph != hrcd_pkg::PH_GOOD) begin
                settle(hrcd_pkg::ST_BAD_LEN);
              end else begin
                length_good = 1;
                body_len    = v;
                if (v == 0) settle(hrcd_pkg::ST_COMPLETE);
              end
            end
          end else begin
            crlf_prog = 2'd2;
          end
        end else begin
          crlf_prog = 2'd0;
        end
      end else if (method_seen == hrcd_pkg::MK_POST && length_good) begin
        body_seen++;
        if (body_seen >= body_len) settle(hrcd_pkg::ST_COMPLETE);
      end
    end
    r.status         = verdict;
    r.method         = (method_seen == hrcd_pkg::MK_GET || method_seen == hrcd_pkg::MK_POST) ?
                       method_seen : hrcd_pkg::MK_PENDING;
    r.content_length = (method_seen == hrcd_pkg::MK_POST && length_good) ?
                       body_len[31:0] : 32'd0;
    return r;
  endfunction

  // Offer one word after a random gap; record its expectation on acceptance
  task automatic send_word(hrcd_pkg::in_word_t w, bit typed, hrcd_pkg::out_word_t typed_word);
    int                  gap;
    hrcd_pkg::out_word_t pred;
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = track_byte(w);
    expected_words.push_back(typed ? typed_word : pred);
    @(negedge clk);
  endtask

  task automatic send_request(ref logic [7:0] q[$], input bit first_sor, input bit typed,
                              input hrcd_pkg::out_word_t typed_word);
    hrcd_pkg::in_word_t w;
    for (int i = 0; i < q.size(); i++) begin
      w.data_byte        = q[i];
      w.start_of_request = (i == 0) ? first_sor : 1'b0;
      send_word(w, typed && (i == q.size() - 1), typed_word);
    end
  endtask

  task automatic add_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(8'(s[i]));
  endtask

  task automatic add_row(bit sor, int raw, string text, bit typed, hrcd_pkg::out_word_t w);
    dir_row_t r;
    r.sor      = sor;
    r.raw      = raw;
    r.text     = text;
    r.typed    = typed;
    r.exp_word = w;
    directed_rows.push_back(r);
  endtask

  // Ordinary header line, with near misses of the length header and a doubled-C spelling that still matches
  task automatic add_header_line(ref logic [7:0] q[$]);
    int n;
    case ($urandom_range(0, 6))
      0: add_text(q, "Host: ");
      1: add_text(q, "Accept: ");
      2: add_text(q, "Content-Type: ");
      3: add_text(q, "Content-Lengt: ");
      4: add_text(q, "CContent-Length: ");
      5: add_text(q, "content-length: ");
      default: add_text(q, "X-Id: ");
    endcase
    n = $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) q.push_back(8'($urandom_range(0, 255)));
      else q.push_back(8'($urandom_range(32, 126)));
    end
    add_text(q, "\r\n");
  endtask

  // Length header with a good or a broken value
  task automatic add_length_line(ref logic [7:0] q[$], input bit lower,
                                 output bit good, output logic [63:0] val);
    good = 0;
    val  = '0;
    add_text(q, lower ? "Content-length: " : "Content-Length: ");
    case ($urandom_range(0, 11))
      0: add_text(q, "\r\n");
      1: add_text(q, $sformatf("%0dx\r\n", $urandom_range(0, 99)));
      2: add_text(q, $sformatf("%0d\rz\r\n", $urandom_range(0, 99)));
      3: add_text(q, $sformatf("%0d\r\n", 64'd4294967296 + 64'($urandom_range(0, 999))));
      4: begin
        val  = 64'($urandom);
        good = 1;
        add_text(q, $sformatf("%0d\r\n", val));
      end
      default: begin
        val  = 64'($urandom_range(0, 24));
        good = 1;
        add_text(q, $sformatf("%s%0d\r\n", ($urandom_range(0, 3) == 0) ? "0" : "", val));
      end
    endcase
  endtask

  // Check each accepted result word against the oldest expectation
  initial begin
    hrcd_pkg::out_word_t want;
    int                  n;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      n = rx_burst ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: status %0d method %0d length %0d",
               out_word.status, out_word.method, out_word.content_length);
        mismatch_cnt++;
      end else begin
        want = expected_words.pop_front();
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word.status);
          mismatch_cnt++;
        end
        if (out_word.method !== want.method) begin
          $error("method: expected %0d, got %0d", want.method, out_word.method);
          mismatch_cnt++;
        end
        if (out_word.content_length !== want.content_length) begin
          $error("content_length: expected %0d, got %0d",
                 want.content_length, out_word.content_length);
          mismatch_cnt++;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    logic [7:0]         req[$];
    hrcd_pkg::in_word_t w;
    bit                 up_good;
    bit                 lo_good;
    bit                 use_up;
    bit                 use_lo;
    logic [63:0]        up_val;
    logic [63:0]        lo_val;
    int                 n;
    int                 cut;
    string              pfx;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    clear_request();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests: byte extremes, both methods, each verdict
    add_row(1, 8'h00, "", 1, '{hrcd_pkg::ST_UNKNOWN, hrcd_pkg::MK_PENDING, 32'd0});
    add_row(0, 8'hFF, "", 1, '{hrcd_pkg::ST_UNKNOWN, hrcd_pkg::MK_PENDING, 32'd0});
    add_row(1, -1, "GET \r\n\r\n", 1, '{hrcd_pkg::ST_COMPLETE, hrcd_pkg::MK_GET, 32'd0});
    add_row(0, -1, "x", 1, '{hrcd_pkg::ST_COMPLETE, hrcd_pkg::MK_GET, 32'd0});
    add_row(1, -1, "GET Content-Length: x\r\n\r\n", 1,
            '{hrcd_pkg::ST_COMPLETE, hrcd_pkg::MK_GET, 32'd0});
    add_row(1, -1, "POST Content-length: 0\r\n\r\n", 1,
            '{hrcd_pkg::ST_COMPLETE, hrcd_pkg::MK_POST, 32'd0});
    add_row(1, -1, "POST Content-Length: 3\r\n\r\nabc", 1,
            '{hrcd_pkg::ST_COMPLETE, hrcd_pkg::MK_POST, 32'd3});
    add_row(1, -1, "POST X: 1\r\n\r\n", 1,
            '{hrcd_pkg::ST_BAD_LEN, hrcd_pkg::MK_POST, 32'd0});
    add_row(1, -1, "POST Content-Length: 1a\r\n\r\n", 1,
            '{hrcd_pkg::ST_BAD_LEN, hrcd_pkg::MK_POST, 32'd0});
    add_row(1, -1, "POST Content-Length: 4294967296\r\n\r\n", 1,
            '{hrcd_pkg::ST_BAD_LEN, hrcd_pkg::MK_POST, 32'd0});
    add_row(1, -1, "POST Content-Length: 4294967295\r\n\r\nxy", 1,
            '{hrcd_pkg::ST_WAITING, hrcd_pkg::MK_POST, 32'hFFFF_FFFF});
    add_row(1, -1, "POST Content-Length: 9\r\nContent-length: 2\r\n\r\nContent-length: 5\r\nab",
            1, '{hrcd_pkg::ST_COMPLETE, hrcd_pkg::MK_POST, 32'd2});
    add_row(1, -1, "POST Content-length: \r\n\r\n", 1,
            '{hrcd_pkg::ST_BAD_LEN, hrcd_pkg::MK_POST, 32'd0});
    add_row(1, -1, "POST Content-Length: 5\r\r\n\r\n", 1,
            '{hrcd_pkg::ST_BAD_LEN, hrcd_pkg::MK_POST, 32'd0});
    add_row(1, -1, "PUT ", 1, '{hrcd_pkg::ST_UNKNOWN, hrcd_pkg::MK_PENDING, 32'd0});
    add_row(1, -1, "GEX", 1, '{hrcd_pkg::ST_UNKNOWN, hrcd_pkg::MK_PENDING, 32'd0});
    add_row(1, -1, "POSTX Content-Length: 1\r\n\r\n", 0, '0);

    foreach (directed_rows[i]) begin
      req.delete();
      if (directed_rows[i].raw >= 0) req.push_back(8'(directed_rows[i].raw));
      else add_text(req, directed_rows[i].text);
      send_request(req, directed_rows[i].sor, directed_rows[i].typed, directed_rows[i].exp_word);
    end

    // Random requests, mostly well formed with random content
    while (live_bytes < TARGET_BYTES) begin
      req.delete();
      case ($urandom_range(0, 9))
        0: begin
          // noise with random start flags
          n = $urandom_range(1, 10);
          for (int i = 0; i < n; i++) begin
            w.data_byte        = 8'($urandom_range(0, 255));
            w.start_of_request = ($urandom_range(0, 3) == 0);
            send_word(w, 0, '0);
          end
        end
        1, 2: begin
          add_text(req, "GET / HTTP/1.1\r\n");
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) add_header_line(req);
          if ($urandom_range(0, 3) == 0) add_length_line(req, $urandom_range(0, 1), up_good, up_val);
          add_text(req, "\r\n");
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) req.push_back(8'($urandom_range(0, 255)));
        end
        9: begin
          // broken method prefix
          if ($urandom_range(0, 1) == 0) begin
            pfx = "POST ";
            add_text(req, pfx.substr(0, $urandom_range(0, 3)));
          end else begin
            pfx = "GET ";
            add_text(req, pfx.substr(0, $urandom_range(0, 2)));
          end
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) req.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          add_text(req, "POST / HTTP/1.1\r\n");
          use_up  = ($urandom_range(0, 3) != 0);
          use_lo  = ($urandom_range(0, 2) == 0);
          up_good = 0;
          lo_good = 0;
          up_val  = '0;
          lo_val  = '0;
          n = $urandom_range(0, 2);
          for (int i = 0; i < n; i++) add_header_line(req);
          if ($urandom_range(0, 1) == 0) begin
            if (use_up) add_length_line(req, 0, up_good, up_val);
            if (use_lo) add_length_line(req, 1, lo_good, lo_val);
          end else begin
            if (use_lo) add_length_line(req, 1, lo_good, lo_val);
            if (use_up) add_length_line(req, 0, up_good, up_val);
          end
          n = $urandom_range(0, 2);
          for (int i = 0; i < n; i++) add_header_line(req);
          add_text(req, "\r\n");
          // body sized to reach completion when the chosen length is small
          if (use_lo ? (lo_good && lo_val <= 40) : (use_up && up_good && up_val <= 40))
            n = int'(use_lo ? lo_val : up_val) + $urandom_range(0, 3);
          else
            n = $urandom_range(0, 6);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) add_text(req, "Content-length: 1\r\n");
            else req.push_back(8'($urandom_range(0, 255)));
          end
        end
      endcase
      if (req.size() > 0) begin
        if ($urandom_range(0, 7) == 0) begin
          cut = $urandom_range(1, req.size());
          while (req.size() > cut) void'(req.pop_back());
        end
        send_request(req, 1, 0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/hrcd_pkg.sv
rtl/hrcd_len_scan.sv
rtl/hrcd_core.sv
rtl/http_request_completion_detector_unit.sv
sim/tb_http_request_completion_detector_unit.sv
